[sv/capsule_point_query_2d_core_macros.svh]
// Assertion macros shared by the capsule query checker.
`ifndef CAPSULE_POINT_QUERY_2D_CORE_MACROS_SVH
`define CAPSULE_POINT_QUERY_2D_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CPQ2_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capsule query check failed");

// Next-cycle implication, off while reset is high.
`define CPQ2_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capsule query check failed");

// Check the cycle that follows a reset cycle.
`define CPQ2_ASSERT_AFTER_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("capsule query reset check failed");

`endif

[sv/cpq2_pkg.sv]
// Shared constants of the capsule point query block.
`default_nettype none
package cpq2_pkg;
  // fraction bits of the clamped projection parameter
  localparam int T_FRAC = 28;
  // extra fraction bits of the distance length
  localparam int L_FRAC = 14;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd4;
endpackage
`default_nettype wire

[sv/cpq2_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cpq2_div_pipe #(
  parameter int QW    = 28,
  parameter int DW    = 65,
  parameter int SIDEW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW+DW-1:0]  num,       // must satisfy num < den * 2^QW
  input  logic [DW-1:0]     den,
  input  logic [SIDEW-1:0]  in_side,
  output logic              out_valid,
  output logic [QW-1:0]     quo,
  output logic [DW-1:0]     rem,
  output logic [DW-1:0]     out_den,
  output logic [SIDEW-1:0]  out_side
);
  logic             st_v    [QW+1];
  logic [DW-1:0]    st_rem  [QW+1];
  logic [QW-1:0]    st_lq   [QW+1];
  logic [DW-1:0]    st_den  [QW+1];
  logic [SIDEW-1:0] st_side [QW+1];

  // stage zero is the request itself
  assign st_v[0]    = in_valid;
  assign st_rem[0]  = num[QW+DW-1:QW];
  assign st_lq[0]   = num[QW-1:0];
  assign st_den[0]  = den;
  assign st_side[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;
    logic             v;
    logic [DW-1:0]    rem_q;
    logic [QW-1:0]    lq_q;
    logic [DW-1:0]    den_q;
    logic [SIDEW-1:0] side_q;

    // shift in the next numerator bit and try a subtract
    always_comb begin
      trial = {st_rem[i], st_lq[i][QW-1]};
      diff  = trial - {1'b0, st_den[i]};
      ge    = (trial >= {1'b0, st_den[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= st_v[i];
      end
    end

    // low numerator bits leave at the top while quotient bits enter below
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lq_q   <= {st_lq[i][QW-2:0], ge};
        den_q  <= st_den[i];
        side_q <= st_side[i];
      end
    end

    assign st_v[i+1]    = v;
    assign st_rem[i+1]  = rem_q;
    assign st_lq[i+1]   = lq_q;
    assign st_den[i+1]  = den_q;
    assign st_side[i+1] = side_q;
  end

  assign out_valid = st_v[QW];
  assign quo       = st_lq[QW];
  assign rem       = st_rem[QW];
  assign out_den   = st_den[QW];
  assign out_side  = st_side[QW];
endmodule
`default_nettype wire

[sv/cpq2_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module cpq2_sqrt_pipe #(
  parameter int SW    = 47,
  parameter int SIDEW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*SW-1:0]   val,
  input  logic [SIDEW-1:0]  in_side,
  output logic              out_valid,
  output logic [SW-1:0]     root,
  output logic [SIDEW-1:0]  out_side
);
  localparam int RW = SW + 2;

  logic             st_v    [SW+1];
  logic [RW-1:0]    st_rem  [SW+1];
  logic [SW-1:0]    st_root [SW+1];
  logic [2*SW-1:0]  st_val  [SW+1];
  logic [SIDEW-1:0] st_side [SW+1];

  assign st_v[0]    = in_valid;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_val[0]  = val;
  assign st_side[0] = in_side;

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    logic             ge;
    logic             v;
    logic [RW-1:0]    rem_q;
    logic [SW-1:0]    root_q;
    logic [2*SW-1:0]  val_q;
    logic [SIDEW-1:0] side_q;

    // bring down two radicand bits and test root*4+1
    always_comb begin
      cur   = {st_rem[i][SW-1:0], st_val[i][2*SW-1:2*SW-2]};
      trial = {st_root[i], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= st_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q  <= ge ? (cur - trial) : cur;
        root_q <= {st_root[i][SW-2:0], ge};
        val_q  <= {st_val[i][2*SW-3:0], 2'b00};
        side_q <= st_side[i];
      end
    end

    assign st_v[i+1]    = v;
    assign st_rem[i+1]  = rem_q;
    assign st_root[i+1] = root_q;
    assign st_val[i+1]  = val_q;
    assign st_side[i+1] = side_q;
  end

  assign out_valid = st_v[SW];
  assign root      = st_root[SW];
  assign out_side  = st_side[SW];
endmodule
`default_nettype wire

[sv/capsule_point_query_2d_core.sv]
// Top level of the 2D capsule point query pipeline.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: point_x, point_y
//   m_axis    out  tvalid/tready         tdata: nearest_x, nearest_y; tuser: inside_res
//   cfg       in   cfg_wr_en (no wait)   cfg_index, cfg_data
//
// One query enters per cycle unless a held result stalls the pipeline; the longest parts
// are the projection divider (28 stages), the distance square root
// (COORD_WIDTH+15 stages) and the radial divider (COORD_WIDTH+1 stages).
// rst is synchronous and clears the valid bits and the capsule registers.
// A held result stalls the whole pipeline in place; s_axis_tready drops with it.
// Values derived from the capsule registers are registered in steps after a write.
`default_nettype none
module capsule_point_query_2d_core #(
  parameter int COORD_WIDTH = 32,
  localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cpq2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [TDATA_W-1:0]            s_axis_tdata,   // point_x, point_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TDATA_W-1:0]            m_axis_tdata,   // nearest_x, nearest_y, zero pad
  output logic [0:0]                    m_axis_tuser    // inside_res
);
  localparam int CW    = COORD_WIDTH;
  localparam int TQ    = cpq2_pkg::T_FRAC;
  localparam int LF    = cpq2_pkg::L_FRAC;
  localparam int L2W   = 2 * CW + 1;
  localparam int DOTW  = 2 * CW + 2;
  localparam int SEGW  = CW + TQ;
  localparam int VW    = L2W + 2 * LF;
  localparam int SW    = (VW + 1) / 2;
  localparam int PW    = 2 * CW - 1;
  localparam int RQW   = CW + 1;
  localparam int RNW   = RQW + SW;
  localparam int TSIDE = 2 * CW + 2;
  localparam int QSIDE = 6 * CW + 3;
  localparam int XSIDE = 2 * CW + 2;
  localparam int YSIDE = 2 * CW + 1;
  localparam logic [SEGW:0] HALF_T = (SEGW + 1)'(1) << (TQ - 1);

  // capsule registers
  logic [CW-1:0]   start_x, start_y, end_x, end_y;
  logic [CW-2:0]   radius;
  // values derived from them
  logic [CW:0]     dx, dy;
  logic [CW-1:0]   dx_mag, dy_mag;
  logic [2*CW-1:0] dx_sq, dy_sq;
  logic [L2W-1:0]  len2;
  logic [2*CW-3:0] rad_sq;

  logic adv;

  // pipeline registers
  logic            a_v;
  logic [CW-1:0]   a_px, a_py;
  logic            b_v;
  logic [CW-1:0]   b_px, b_py;
  logic [CW:0]     b_wx, b_wy;
  logic            c_v;
  logic [CW-1:0]   c_px, c_py;
  logic [2*CW-1:0] c_t1, c_t2;
  logic            c_n1, c_n2;
  logic            d_v;
  logic [CW-1:0]   d_px, d_py;
  logic [DOTW-1:0] d_dot;
  logic            f_v;
  logic [CW-1:0]   f_px, f_py;
  logic            f_use_end, f_use_mid;
  logic [SEGW-1:0] f_mx, f_my;
  logic            g_v;
  logic [CW-1:0]   g_px, g_py, g_qx, g_qy;
  logic            h_v;
  logic [CW-1:0]   h_px, h_py, h_qx, h_qy;
  logic [CW:0]     h_gx, h_gy;
  logic            i_v;
  logic [CW-1:0]   i_px, i_py, i_qx, i_qy, i_gxm, i_gym;
  logic            i_sgx, i_sgy;
  logic [2*CW-1:0] i_sqx, i_sqy;
  logic            j_v;
  logic [CW-1:0]   j_px, j_py, j_qx, j_qy, j_gxm, j_gym;
  logic            j_sgx, j_sgy, j_inside;
  logic [L2W-1:0]  j_dist2;
  logic            k_v;
  logic [CW-1:0]   k_px, k_py, k_qx, k_qy;
  logic            k_sgx, k_sgy, k_inside;
  logic [SW-1:0]   k_len;
  logic [PW-1:0]   k_nx, k_ny;
  logic            o_v, o_inside;
  logic [CW-1:0]   o_nx, o_ny;

  // capsule register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
      radius  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cpq2_pkg::CFG_START_X: start_x <= cfg_data;
        cpq2_pkg::CFG_START_Y: start_y <= cfg_data;
        cpq2_pkg::CFG_END_X:   end_x   <= cfg_data;
        cpq2_pkg::CFG_END_Y:   end_y   <= cfg_data;
        cpq2_pkg::CFG_RADIUS:  radius  <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // derive direction, its magnitudes and squared length
  logic [CW:0] dx_neg, dy_neg;
  always_comb begin
    dx_neg = -dx;
    dy_neg = -dy;
  end

  always_ff @(posedge clk) begin
    dx     <= {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    dy     <= {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    dx_mag <= dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
    dy_mag <= dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
    dx_sq  <= dx_mag * dx_mag;
    dy_sq  <= dy_mag * dy_mag;
    len2   <= {1'b0, dx_sq} + {1'b0, dy_sq};
    rad_sq <= radius * radius;
  end

  // the pipeline moves whenever the result slot is free or being taken
  assign adv           = !o_v || m_axis_tready;
  assign s_axis_tready = adv;

  // valid bits
  logic t_v, q_v, rx_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
      k_v <= 1'b0;
      o_v <= 1'b0;
    end else if (adv) begin
      a_v <= s_axis_tvalid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      f_v <= t_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
      k_v <= q_v;
      o_v <= rx_v;
    end
  end

  // capture the request, form offsets from the start point
  always_ff @(posedge clk) begin
    if (adv) begin
      a_px <= s_axis_tdata[CW-1:0];
      a_py <= s_axis_tdata[2*CW-1:CW];
      b_px <= a_px;
      b_py <= a_py;
      b_wx <= {a_px[CW-1], a_px} - {start_x[CW-1], start_x};
      b_wy <= {a_py[CW-1], a_py} - {start_y[CW-1], start_y};
    end
  end

  // dot product terms as magnitude products with signs
  logic [CW:0]   wx_neg, wy_neg;
  logic [CW-1:0] wx_mag, wy_mag;
  always_comb begin
    wx_neg = -b_wx;
    wy_neg = -b_wy;
    wx_mag = b_wx[CW] ? wx_neg[CW-1:0] : b_wx[CW-1:0];
    wy_mag = b_wy[CW] ? wy_neg[CW-1:0] : b_wy[CW-1:0];
  end

  logic [DOTW-1:0] t1_ext, t2_ext;
  always_comb begin
    t1_ext = {2'b00, c_t1};
    t2_ext = {2'b00, c_t2};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_px  <= b_px;
      c_py  <= b_py;
      c_t1  <= wx_mag * dx_mag;
      c_t2  <= wy_mag * dy_mag;
      c_n1  <= b_wx[CW] ^ dx[CW];
      c_n2  <= b_wy[CW] ^ dy[CW];
      d_px  <= c_px;
      d_py  <= c_py;
      d_dot <= (c_n1 ? -t1_ext : t1_ext) + (c_n2 ? -t2_ext : t2_ext);
    end
  end

  // classify the projection: before start, past end or in between
  logic             dot_pos, len_nz, use_end, use_mid;
  logic [L2W-1:0]   dot_mag;
  logic [TSIDE-1:0] t_side_in, t_side;
  logic [TQ-1:0]    t_quo;
  always_comb begin
    dot_mag   = d_dot[L2W-1:0];
    dot_pos   = !d_dot[DOTW-1] && (d_dot != '0);
    len_nz    = (len2 != '0);
    use_end   = len_nz && dot_pos && (dot_mag >= len2);
    use_mid   = len_nz && dot_pos && (dot_mag < len2);
    t_side_in = {d_px, d_py, use_end, use_mid};
  end

  // t = floor(dot * 2^TQ / len2)
  cpq2_div_pipe #(
    .QW    (TQ),
    .DW    (L2W),
    .SIDEW (TSIDE)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_v),
    .num       ({dot_mag, {TQ{1'b0}}}),
    .den       (len2),
    .in_side   (t_side_in),
    .out_valid (t_v),
    .quo       (t_quo),
    .rem       (),
    .out_den   (),
    .out_side  (t_side)
  );

  // scale the direction by t
  always_ff @(posedge clk) begin
    if (adv) begin
      {f_px, f_py, f_use_end, f_use_mid} <= t_side;
      f_mx <= dx_mag * t_quo;
      f_my <= dy_mag * t_quo;
    end
  end

  // round the offsets and pick the nearest segment point
  logic [SEGW:0] rnd_x, rnd_y;
  logic [CW:0]   off_x, off_y;
  logic [CW+1:0] mid_x, mid_y;
  logic [CW-1:0] seg_x, seg_y;
  always_comb begin
    rnd_x = {1'b0, f_mx} + HALF_T;
    rnd_y = {1'b0, f_my} + HALF_T;
    off_x = rnd_x[SEGW:TQ];
    off_y = rnd_y[SEGW:TQ];
    mid_x = dx[CW] ? ({{2{start_x[CW-1]}}, start_x} - {1'b0, off_x})
                   : ({{2{start_x[CW-1]}}, start_x} + {1'b0, off_x});
    mid_y = dy[CW] ? ({{2{start_y[CW-1]}}, start_y} - {1'b0, off_y})
                   : ({{2{start_y[CW-1]}}, start_y} + {1'b0, off_y});
    if (f_use_end) begin
      seg_x = end_x;
      seg_y = end_y;
    end else if (f_use_mid) begin
      seg_x = mid_x[CW-1:0];
      seg_y = mid_y[CW-1:0];
    end else begin
      seg_x = start_x;
      seg_y = start_y;
    end
  end

  // gap vector from the segment point to the query point
  logic [CW:0]   gx_neg, gy_neg;
  always_comb begin
    gx_neg = -h_gx;
    gy_neg = -h_gy;
  end

  logic [CW-1:0] gx_mag, gy_mag;
  always_comb begin
    gx_mag = h_gx[CW] ? gx_neg[CW-1:0] : h_gx[CW-1:0];
    gy_mag = h_gy[CW] ? gy_neg[CW-1:0] : h_gy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_px     <= f_px;
      g_py     <= f_py;
      g_qx     <= seg_x;
      g_qy     <= seg_y;
      h_px     <= g_px;
      h_py     <= g_py;
      h_qx     <= g_qx;
      h_qy     <= g_qy;
      h_gx     <= {g_px[CW-1], g_px} - {g_qx[CW-1], g_qx};
      h_gy     <= {g_py[CW-1], g_py} - {g_qy[CW-1], g_qy};
      i_px     <= h_px;
      i_py     <= h_py;
      i_qx     <= h_qx;
      i_qy     <= h_qy;
      i_gxm    <= gx_mag;
      i_gym    <= gy_mag;
      i_sgx    <= h_gx[CW];
      i_sgy    <= h_gy[CW];
      i_sqx    <= gx_mag * gx_mag;
      i_sqy    <= gy_mag * gy_mag;
      j_px     <= i_px;
      j_py     <= i_py;
      j_qx     <= i_qx;
      j_qy     <= i_qy;
      j_gxm    <= i_gxm;
      j_gym    <= i_gym;
      j_sgx    <= i_sgx;
      j_sgy    <= i_sgy;
      j_dist2  <= {1'b0, i_sqx} + {1'b0, i_sqy};
      j_inside <= (({1'b0, i_sqx} + {1'b0, i_sqy}) <= L2W'(rad_sq));
    end
  end

  // gap length with LF extra fraction bits
  logic [QSIDE-1:0] q_side_in, q_side;
  logic [SW-1:0]    q_len;
  logic [CW-1:0]    q_px, q_py, q_qx, q_qy, q_gxm, q_gym;
  logic             q_sgx, q_sgy, q_inside;
  always_comb begin
    q_side_in = {j_inside, j_sgx, j_sgy, j_gxm, j_gym, j_qx, j_qy, j_px, j_py};
    {q_inside, q_sgx, q_sgy, q_gxm, q_gym, q_qx, q_qy, q_px, q_py} = q_side;
  end

  cpq2_sqrt_pipe #(
    .SW    (SW),
    .SIDEW (QSIDE)
  ) u_len (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (j_v),
    .val       ((2 * SW)'({j_dist2, {(2 * LF){1'b0}}})),
    .in_side   (q_side_in),
    .out_valid (q_v),
    .root      (q_len),
    .out_side  (q_side)
  );

  // radial numerators |g| * radius
  always_ff @(posedge clk) begin
    if (adv) begin
      k_px     <= q_px;
      k_py     <= q_py;
      k_qx     <= q_qx;
      k_qy     <= q_qy;
      k_sgx    <= q_sgx;
      k_sgy    <= q_sgy;
      k_inside <= q_inside;
      k_len    <= q_len;
      k_nx     <= q_gxm * radius;
      k_ny     <= q_gym * radius;
    end
  end

  // radial offsets, x and y in lockstep
  logic [RQW-1:0]   rx_quo, ry_quo;
  logic [SW-1:0]    rx_rem, ry_rem, rx_den, ry_den;
  logic [XSIDE-1:0] rx_side;
  logic [YSIDE-1:0] ry_side;

  cpq2_div_pipe #(
    .QW    (RQW),
    .DW    (SW),
    .SIDEW (XSIDE)
  ) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (k_v),
    .num       (RNW'({k_nx, {LF{1'b0}}})),
    .den       (k_len),
    .in_side   ({k_inside, k_sgx, k_qx, k_px}),
    .out_valid (rx_v),
    .quo       (rx_quo),
    .rem       (rx_rem),
    .out_den   (rx_den),
    .out_side  (rx_side)
  );

  cpq2_div_pipe #(
    .QW    (RQW),
    .DW    (SW),
    .SIDEW (YSIDE)
  ) u_ydiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (k_v),
    .num       (RNW'({k_ny, {LF{1'b0}}})),
    .den       (k_len),
    .in_side   ({k_sgy, k_qy, k_py}),
    .out_valid (),
    .quo       (ry_quo),
    .rem       (ry_rem),
    .out_den   (ry_den),
    .out_side  (ry_side)
  );

  // round half up, apply along the gap sign, saturate
  logic          r_inside, r_sgx, r_sgy;
  logic [CW-1:0] r_qx, r_px, r_qy, r_py;
  logic [CW+1:0] roff_x, roff_y;
  logic [CW+2:0] sum_x, sum_y;
  logic [CW-1:0] sat_x, sat_y;
  logic [CW-1:0] max_c, min_c;
  always_comb begin
    {r_inside, r_sgx, r_qx, r_px} = rx_side;
    {r_sgy, r_qy, r_py}           = ry_side;
    max_c  = {1'b0, {(CW - 1){1'b1}}};
    min_c  = {1'b1, {(CW - 1){1'b0}}};
    roff_x = {1'b0, rx_quo} + (CW + 2)'({rx_rem, 1'b0} >= {1'b0, rx_den});
    roff_y = {1'b0, ry_quo} + (CW + 2)'({ry_rem, 1'b0} >= {1'b0, ry_den});
    sum_x  = r_sgx ? ({{3{r_qx[CW-1]}}, r_qx} - {1'b0, roff_x})
                   : ({{3{r_qx[CW-1]}}, r_qx} + {1'b0, roff_x});
    sum_y  = r_sgy ? ({{3{r_qy[CW-1]}}, r_qy} - {1'b0, roff_y})
                   : ({{3{r_qy[CW-1]}}, r_qy} + {1'b0, roff_y});
    if ((&sum_x[CW+2:CW-1]) || !(|sum_x[CW+2:CW-1])) begin
      sat_x = sum_x[CW-1:0];
    end else begin
      sat_x = sum_x[CW+2] ? min_c : max_c;
    end
    if ((&sum_y[CW+2:CW-1]) || !(|sum_y[CW+2:CW-1])) begin
      sat_y = sum_y[CW-1:0];
    end else begin
      sat_y = sum_y[CW+2] ? min_c : max_c;
    end
  end

  // result register: the query point itself when inside
  always_ff @(posedge clk) begin
    if (adv) begin
      o_inside <= r_inside;
      o_nx     <= r_inside ? r_px : sat_x;
      o_ny     <= r_inside ? r_py : sat_y;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = TDATA_W'({o_ny, o_nx});
  assign m_axis_tuser  = o_inside;
endmodule
`default_nettype wire

[sv/cpq2_checker.sv]
// Port-level checks of the capsule query core, bound to the top level.
`default_nettype none
`include "capsule_point_query_2d_core_macros.svh"
module cpq2_checker #(
  parameter int COORD_WIDTH = 32,
  localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [TDATA_W-1:0]             m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  // a held result keeps its payload
  `CPQ2_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // an empty result slot always takes a request
  `CPQ2_ASSERT_IMPLY(a_ready_free, clk, rst, !m_axis_tvalid, s_axis_tready)
  // a stalled result holds the whole pipeline
  `CPQ2_ASSERT_IMPLY(a_ready_stall, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // reset empties the result slot
  `CPQ2_ASSERT_AFTER_RST(a_rst_empty, clk, rst, !m_axis_tvalid)
endmodule

bind capsule_point_query_2d_core cpq2_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpq2_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the 2D capsule point query pipeline.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int IDX_W = cpq2_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] CFG_NO_REG = 3'd6;
  localparam logic [IDX_W-1:0] CFG_NO_REG_HI = 3'd7;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] near_x;
    logic [CW-1:0] near_y;
  } capsule_hit_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready;
  logic [2*CW-1:0] s_axis_tdata;   // point_x, point_y
  logic m_axis_tvalid, m_axis_tready;
  logic [2*CW-1:0] m_axis_tdata;   // nearest_x, nearest_y
  logic [0:0] m_axis_tuser;        // inside_res

  capsule_point_query_2d_core #(.COORD_WIDTH(CW)) uut (.*);

  // capsule as the block should hold it
  logic [CW-1:0] cap_sx, cap_sy, cap_ex, cap_ey;
  logic [CW-2:0] cap_r;

  capsule_hit_t hit_q[$];
  int send_idle_pct, recv_stall_pct;
  int mismatches, results_seen, requests_sent, cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [127:0] mag128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // nearest segment coordinate: base + d*t, magnitude rounded half away
  function automatic longint seg_point(input longint base, input longint d,
                                       input logic [127:0] tq);
    logic [127:0] off;
    off = (mag128(d) * tq + (128'd1 << (cpq2_pkg::T_FRAC - 1))) >> cpq2_pkg::T_FRAC;
    return d < 0 ? base - longint'(off) : base + longint'(off);
  endfunction

  // push q out along e by the radius, then saturate
  function automatic logic [CW-1:0] push_out(input longint q, input longint e,
                                             input logic [127:0] len);
    logic [127:0] num, quo, rem;
    longint v;
    num = (mag128(e) * cap_r) << cpq2_pkg::L_FRAC;
    quo = num / len;
    rem = num % len;
    if ((rem << 1) >= len) quo = quo + 1;
    v = e < 0 ? q - longint'(quo) : q + longint'(quo);
    if (v > 64'sh7fffffff) v = 64'sh7fffffff;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[CW-1:0];
  endfunction

  function automatic capsule_hit_t capsule_query(input logic [CW-1:0] px_b,
                                                 input logic [CW-1:0] py_b);
    longint px, py, sx, sy, ex, ey, dx, dy, qx, qy, gx, gy;
    logic signed [127:0] a, b, c, d, dot, len2, dist2;
    logic [127:0] tq, v, len, cand;
    capsule_hit_t h;
    px = $signed(px_b); py = $signed(py_b);
    sx = $signed(cap_sx); sy = $signed(cap_sy);
    ex = $signed(cap_ex); ey = $signed(cap_ey);
    dx = ex - sx; dy = ey - sy;
    a = px - sx; b = dx; c = py - sy; d = dy;
    dot = a * b + c * d;
    len2 = b * b + d * d;
    qx = sx; qy = sy;
    if (len2 != 0 && dot > 0) begin
      if (dot >= len2) begin
        qx = ex; qy = ey;
      end else begin
        tq = (dot << cpq2_pkg::T_FRAC) / len2;
        qx = seg_point(sx, dx, tq);
        qy = seg_point(sy, dy, tq);
      end
    end
    gx = px - qx; gy = py - qy;
    a = gx; c = gy;
    dist2 = a * a + c * c;
    h.hit = dist2 <= 128'(cap_r) * 128'(cap_r);
    h.near_x = px_b;
    h.near_y = py_b;
    if (!h.hit) begin
      v = dist2 << (2 * cpq2_pkg::L_FRAC);
      len = 0;
      for (int i = 63; i >= 0; i--) begin
        cand = len | (128'd1 << i);
        if (cand * cand <= v) len = cand;
      end
      h.near_x = push_out(qx, gx, len);
      h.near_y = push_out(qy, gy, len);
    end
    return h;
  endfunction

  // result consumer: random stall per phase
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result taken; signals are stable at the falling edge
  always @(negedge clk) begin
    capsule_hit_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tuser[0];
      got.near_x = m_axis_tdata[CW-1:0];
      got.near_y = m_axis_tdata[2*CW-1:CW];
      results_seen++;
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = hit_q.pop_front();
        if (got.hit !== want.hit || got.near_x !== want.near_x ||
            got.near_y !== want.near_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected inside=%0d x=%h y=%h, got inside=%0d x=%h y=%h",
                     want.hit, want.near_x, want.near_y,
                     got.hit, got.near_x, got.near_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, hit_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // send one query; valid stays high into the next request unless a gap follows
  task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {py, px};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    hit_q.push_back(capsule_query(px, py));
    requests_sent++;
  endtask

  task automatic drain();
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    wait (hit_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      cpq2_pkg::CFG_START_X: cap_sx = val;
      cpq2_pkg::CFG_START_Y: cap_sy = val;
      cpq2_pkg::CFG_END_X:   cap_ex = val;
      cpq2_pkg::CFG_END_Y:   cap_ey = val;
      cpq2_pkg::CFG_RADIUS:  cap_r = val[CW-2:0];
      default: ;
    endcase
  endtask

  // load a full capsule while the pipeline is empty, then let it settle
  task automatic set_capsule(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                             input logic [CW-1:0] r);
    drain();
    write_reg(cpq2_pkg::CFG_START_X, sx);
    write_reg(cpq2_pkg::CFG_START_Y, sy);
    write_reg(cpq2_pkg::CFG_END_X, ex);
    write_reg(cpq2_pkg::CFG_END_Y, ey);
    write_reg(cpq2_pkg::CFG_RADIUS, r);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] jitter(input logic [CW-1:0] base);
    logic [CW-1:0] off;
    off = $urandom >> $urandom_range(31);
    return $urandom_range(1) ? base + off : base - off;
  endfunction

  // extremes, end clamps, zero segment, zero radius, masked bits
  task automatic test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_point(32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0);
    set_capsule(32'hffff_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h8000_8000);
    send_point(32'h0, 32'h0);
    send_point(32'hfffe_0000, 32'h0);
    send_point(32'h0005_0000, 32'h0003_0000);
    send_point(32'h0, 32'h0000_8000);
    send_point(32'h0, 32'h0000_8001);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    drain();
    write_reg(CFG_NO_REG, 32'hdead_beef);
    write_reg(CFG_NO_REG_HI, 32'h1234_5678);
    send_point(32'h0, 32'h0001_0000);
    set_capsule(32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    send_point(32'h0002_0000, 32'h0003_0000);
    send_point(32'h0002_0001, 32'h0003_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    set_capsule(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h0, 32'h0);
    send_point(32'hffff_ffff, 32'h0000_0001);
    set_capsule(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    drain();
  endtask

  // random queries around the capsule, some anywhere in the plane
  task automatic test_random_queries(input int n, input int idle, input int stall);
    logic [CW-1:0] px, py;
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin px = $urandom; py = $urandom; end
        1: begin px = jitter(cap_sx); py = jitter(cap_sy); end
        2: begin px = jitter(cap_ex); py = jitter(cap_ey); end
        default: begin
          px = jitter(cap_sx + ((cap_ex - cap_sx) >>> 1));
          py = jitter(cap_sy + ((cap_ey - cap_sy) >>> 1));
        end
      endcase
      send_point(px, py);
      // hold off once until the pipeline is empty
      if (i == n / 2 && idle != 0) drain();
    end
  endtask

  task automatic test_random_capsules();
    int idle_mix[4] = '{0, 58, 0, 38};
    int stall_mix[4] = '{0, 0, 58, 38};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0)
        set_capsule($urandom, $urandom, $urandom, $urandom, $urandom);
      else if (ph % 3 == 1)
        set_capsule(32'(int'($urandom_range(2000)) - 1000) << 16,
                    32'(int'($urandom_range(2000)) - 1000) << 16,
                    32'(int'($urandom_range(2000)) - 1000) << 16,
                    32'(int'($urandom_range(2000)) - 1000) << 16,
                    32'($urandom_range(50)) << $urandom_range(16));
      else
        set_capsule($urandom, $urandom, $urandom, $urandom,
                    $urandom >> $urandom_range(31));
      test_random_queries(160, idle_mix[ph % 4], stall_mix[ph % 4]);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cap_sx = '0; cap_sy = '0; cap_ex = '0; cap_ey = '0; cap_r = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_capsules();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d queries and %0d results over reset, extreme and random capsules,",
             requests_sent, results_seen);
    $display("with sender gaps and receiver stalls in every mix; %0d mismatches", mismatches);
    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
